@@ sv/cau_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and helpers of the complex accumulator unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_W        = 32;
  localparam int PROD_W        = 64;
  localparam int QUO_W         = DATA_W + 1;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_MUL  = 2'd2;
  localparam logic [1:0] OP_DIV  = 2'd3;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] mag;
  } smag_t;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } sat_t;

  function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] x);
    abs32 = x[DATA_W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic smag_t smag_add(input smag_t x, input smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg;
      r.mag = y.mag - x.mag;
    end
    if (r.mag == '0) begin
      r.neg = 1'b0;
    end
    return r;
  endfunction

  function automatic sat_t saturate(input logic neg, input logic [PROD_W-1:0] mag);
    sat_t r;
    r.ovf = 1'b0;
    if (!neg) begin
      if (mag > {{(PROD_W-DATA_W){1'b0}}, SAT_MAX}) begin
        r.ovf = 1'b1;
        r.val = SAT_MAX;
      end else begin
        r.val = mag[DATA_W-1:0];
      end
    end else begin
      if (mag > {{(PROD_W-DATA_W){1'b0}}, SAT_MIN}) begin
        r.ovf = 1'b1;
        r.val = SAT_MIN;
      end else begin
        r.val = '0 - mag[DATA_W-1:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/complex_accumulator_alu_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Load, add and divide by zero go from the request straight to the result;
// multiply first runs the partial products through the shared multiplier,
// and divide also runs the one-bit-a-cycle divider.
// One request at a time: the next is taken once the result is registered.
// Synchronous reset clears the accumulator to zero and drops any result.
// ----------------------------------------------------------------------------
// complex_accumulator_alu_top
// Complex Q-format accumulator: load, add, multiply and divide by the operand,
// built around one shared multiplier and a shared iterative divider.
// ----------------------------------------------------------------------------
module complex_accumulator_alu_top
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // operand_real, operand_imag
  input  wire logic [1:0]  s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [63:0] m_axis_tdata,  // result_real, result_imag
  output logic      [1:0]  m_axis_tuser   // overflow, divide_by_zero
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]        state;
  logic [1:0]        op_q;
  logic [DATA_W-1:0] c_q, d_q;
  logic              dz_q;
  logic [2:0]        step;
  logic [2:0]        last;
  logic [2:0]        j;
  logic              prod_neg;
  smag_t             re, im, den;
  logic              div_go;
  logic              div_done;
  logic [QUO_W-1:0]  q_re, q_im;
  logic [DATA_W-1:0] acc_real, acc_imag;

  logic [DATA_W-1:0] abs_a, abs_b, abs_c, abs_d;
  logic [DATA_W-1:0] mx, my;
  logic              sx, sy;
  logic [PROD_W-1:0] prod;
  smag_t             term, lhs, sum;
  logic              flip;
  logic              s_acc, out_free;
  logic [DATA_W:0]   add_re, add_im;
  sat_t              r_re, r_im;
  logic              res_dz;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign abs_a = abs32(acc_real);
  assign abs_b = abs32(acc_imag);
  assign abs_c = abs32(c_q);
  assign abs_d = abs32(d_q);

  assign last = (op_q == OP_MUL) ? 3'd4 : 3'd6;
  assign j    = step - 3'd1;

  always_comb begin
    case (step) inside
      3'd0, 3'd3: begin
        mx = abs_a;
        sx = acc_real[DATA_W-1];
      end
      3'd1, 3'd2: begin
        mx = abs_b;
        sx = acc_imag[DATA_W-1];
      end
      3'd4: begin
        mx = abs_c;
        sx = c_q[DATA_W-1];
      end
      default: begin
        mx = abs_d;
        sx = d_q[DATA_W-1];
      end
    endcase
    case (step) inside
      3'd0, 3'd2, 3'd4: begin
        my = abs_c;
        sy = c_q[DATA_W-1];
      end
      default: begin
        my = abs_d;
        sy = d_q[DATA_W-1];
      end
    endcase
  end

  cau_mul u_mul (
    .clk (clk),
    .x   (mx),
    .y   (my),
    .p   (prod)
  );

  always_comb begin
    flip     = ((op_q == OP_MUL) && (j == 3'd1)) || ((op_q == OP_DIV) && (j == 3'd3));
    term.neg = prod_neg ^ flip;
    term.mag = prod;
    case (j)
      3'd1:    lhs = re;
      3'd3:    lhs = im;
      default: lhs = den;
    endcase
    sum = smag_add(lhs, term);
  end

  cau_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_go),
    .num_re (re.mag),
    .num_im (im.mag),
    .den    (den.mag),
    .done   (div_done),
    .q_re   (q_re),
    .q_im   (q_im)
  );

  always_comb begin
    add_re = {acc_real[DATA_W-1], acc_real} + {c_q[DATA_W-1], c_q};
    add_im = {acc_imag[DATA_W-1], acc_imag} + {d_q[DATA_W-1], d_q};
    res_dz = 1'b0;
    unique case (op_q)
      OP_LOAD: begin
        r_re = '{ovf: 1'b0, val: c_q};
        r_im = '{ovf: 1'b0, val: d_q};
      end
      OP_ADD: begin
        r_re.ovf = add_re[DATA_W] ^ add_re[DATA_W-1];
        r_re.val = r_re.ovf ? (add_re[DATA_W] ? SAT_MIN : SAT_MAX) : add_re[DATA_W-1:0];
        r_im.ovf = add_im[DATA_W] ^ add_im[DATA_W-1];
        r_im.val = r_im.ovf ? (add_im[DATA_W] ? SAT_MIN : SAT_MAX) : add_im[DATA_W-1:0];
      end
      OP_MUL: begin
        r_re = saturate(re.neg, re.mag >> FRAC_BITS);
        r_im = saturate(im.neg, im.mag >> FRAC_BITS);
      end
      default: begin
        if (dz_q) begin
          res_dz = 1'b1;
          r_re   = '{ovf: 1'b0, val: acc_real};
          r_im   = '{ovf: 1'b0, val: acc_imag};
        end else begin
          r_re = saturate(re.neg, PROD_W'(q_re));
          r_im = saturate(im.neg, PROD_W'(q_im));
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      div_go        <= 1'b0;
      m_axis_tvalid <= 1'b0;
      acc_real      <= '0;
      acc_imag      <= '0;
    end else begin
      div_go <= (state == ST_MUL) && (step == last) && (op_q != OP_MUL);
      if ((state == ST_FIN) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            step <= '0;
            if ((s_axis_tuser == OP_MUL) ||
                ((s_axis_tuser == OP_DIV) && (s_axis_tdata != '0))) begin
              state <= ST_MUL;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_MUL: begin
          step <= step + 3'd1;
          if (step == last) begin
            if (op_q == OP_MUL) begin
              state <= ST_FIN;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FIN;
          end
        end
        default: begin
          if (out_free) begin
            acc_real <= r_re.val;
            acc_imag <= r_im.val;
            state    <= ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_neg <= sx ^ sy;
    if (s_acc) begin
      op_q <= s_axis_tuser;
      c_q  <= s_axis_tdata[31:0];
      d_q  <= s_axis_tdata[63:32];
      dz_q <= (s_axis_tuser == OP_DIV) && (s_axis_tdata == '0);
    end
    if ((state == ST_MUL) && (step != 3'd0)) begin
      case (j)
        3'd0:    re  <= term;
        3'd1:    re  <= sum;
        3'd2:    im  <= term;
        3'd3:    im  <= sum;
        3'd4:    den <= term;
        3'd5:    den <= sum;
        default: ;
      endcase
    end
    if ((state == ST_FIN) && out_free) begin
      m_axis_tdata <= {r_im.val, r_re.val};
      m_axis_tuser <= {res_dz, r_re.ovf | r_im.ovf};
    end
  end

endmodule
`default_nettype wire

@@ sv/cau_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_mul
// Shared unsigned 32 x 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module cau_mul
  import cau_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [DATA_W-1:0] x,
  input  wire logic [DATA_W-1:0] y,
  output logic      [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(x) * PROD_W'(y);
  end

endmodule
`default_nettype wire

@@ sv/cau_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div
// Two-lane restoring divider: floor(num * 2^FRAC_BITS / den), one bit a cycle.
// A quotient that passes 32 bits freezes, which the caller saturates.
// ----------------------------------------------------------------------------
module cau_div
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] num_re,
  input  wire logic [PROD_W-1:0] num_im,
  input  wire logic [PROD_W-1:0] den,
  output logic                   done,
  output logic      [QUO_W-1:0]  q_re,
  output logic      [QUO_W-1:0]  q_im
);

  localparam int STEPS = PROD_W + FRAC_BITS;
  localparam int CW    = $clog2(STEPS + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [PROD_W-1:0] dvd_re, dvd_im;
  logic [PROD_W-1:0] rem_re, rem_im;
  logic [PROD_W:0]   try_re, try_im;
  logic              fit_re, fit_im;

  assign try_re = {rem_re, dvd_re[PROD_W-1]};
  assign try_im = {rem_im, dvd_im[PROD_W-1]};
  assign fit_re = try_re >= {1'b0, den};
  assign fit_im = try_im >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_re <= num_re;
      dvd_im <= num_im;
      rem_re <= '0;
      rem_im <= '0;
      q_re   <= '0;
      q_im   <= '0;
    end else if (busy) begin
      dvd_re <= {dvd_re[PROD_W-2:0], 1'b0};
      dvd_im <= {dvd_im[PROD_W-2:0], 1'b0};
      rem_re <= fit_re ? PROD_W'(try_re - {1'b0, den}) : try_re[PROD_W-1:0];
      rem_im <= fit_im ? PROD_W'(try_im - {1'b0, den}) : try_im[PROD_W-1:0];
      if (!q_re[QUO_W-1]) begin
        q_re <= {q_re[QUO_W-2:0], fit_re};
      end
      if (!q_im[QUO_W-1]) begin
        q_im <= {q_im[QUO_W-2:0], fit_im};
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/cau_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex accumulator unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while unit busy");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("overflow raised with divide by zero");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("reset left a result or busy unit");

endmodule

bind complex_accumulator_alu_top cau_checker u_cau_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

@@ verif/tb_complex_accumulator_alu_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_accumulator_alu_top
// Self-checking bench for the complex accumulator: a short directed run over
// saturation, truncation and divide-by-zero corners, then random sequences
// of add, multiply and divide, mostly led by a load. Requests go out in
// bursts with random gaps, and the result side stalls on its own pattern.
// Every result is checked field by field against a wide-integer bench model.
// ----------------------------------------------------------------------------
module tb_complex_accumulator_alu_top;
  import cau_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int N_ITEMS   = 1550;
  localparam int DRAIN_GAP = 300;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] re;
    logic [31:0] im;
    logic        drain;
  } request_t;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
    logic        dz;
  } acc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // operand_real, operand_imag
  logic [1:0]  s_axis_tuser = OP_LOAD; // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // result_real, result_imag
  logic [1:0]  m_axis_tuser;        // overflow, divide_by_zero

  request_t    request_q[$];
  acc_result_t acc_results_due[$];
  acc_result_t due;

  logic [31:0] acc_re = '0;
  logic [31:0] acc_im = '0;

  int n_queued = 0;
  int n_accepted = 0;
  int n_returned = 0;
  int n_errors = 0;
  int n_saturated = 0;
  int n_div_zero = 0;
  int op_seen[4] = '{0, 0, 0, 0};
  int gap_left = 0;
  int burst_left = 0;
  int stall_tick = 0;
  int stall_mode = 0;

  complex_accumulator_alu_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [32:0] clamp_word(input logic neg, input logic [127:0] mag);
    if (!neg) begin
      if (mag > 128'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
      return {1'b0, mag[31:0]};
    end
    if (mag > 128'h8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, 32'(32'd0 - mag[31:0])};
  endfunction

  function automatic void step_accumulator(input logic [1:0] op, input logic [31:0] c,
                                           input logic [31:0] d);
    logic signed [127:0] a_w, b_w, c_w, d_w, re_w, im_w;
    logic [127:0] re_mag, im_mag, den;
    logic [32:0] re_sat, im_sat;
    acc_result_t r;
    a_w = {{96{acc_re[31]}}, acc_re};
    b_w = {{96{acc_im[31]}}, acc_im};
    c_w = {{96{c[31]}}, c};
    d_w = {{96{d[31]}}, d};
    re_w = '0;
    im_w = '0;
    den = '1;
    r.ovf = 1'b0;
    r.dz = 1'b0;
    case (op)
      OP_ADD: begin
        re_w = a_w + c_w;
        im_w = b_w + d_w;
      end
      OP_MUL: begin
        re_w = a_w * c_w - b_w * d_w;
        im_w = b_w * c_w + a_w * d_w;
      end
      OP_DIV: begin
        den = c_w * c_w + d_w * d_w;
        re_w = a_w * c_w + b_w * d_w;
        im_w = b_w * c_w - a_w * d_w;
      end
      default: begin
      end
    endcase
    if (op == OP_LOAD) begin
      acc_re = c;
      acc_im = d;
    end else if (op == OP_DIV && den == 0) begin
      r.dz = 1'b1;
    end else begin
      re_mag = re_w[127] ? -re_w : re_w;
      im_mag = im_w[127] ? -im_w : im_w;
      if (op == OP_MUL) begin
        re_mag = re_mag >> FRAC;
        im_mag = im_mag >> FRAC;
      end else if (op == OP_DIV) begin
        re_mag = (re_mag << FRAC) / den;
        im_mag = (im_mag << FRAC) / den;
      end
      re_sat = clamp_word(re_w[127], re_mag);
      im_sat = clamp_word(im_w[127], im_mag);
      acc_re = re_sat[31:0];
      acc_im = im_sat[31:0];
      r.ovf = re_sat[32] | im_sat[32];
    end
    r.re = acc_re;
    r.im = acc_im;
    op_seen[op]++;
    if (r.ovf) n_saturated++;
    if (r.dz) n_div_zero++;
    acc_results_due.push_back(r);
  endfunction

  function automatic void queue_request(input logic [1:0] op, input logic [31:0] re,
                                        input logic [31:0] im);
    request_t q;
    q.op = op;
    q.re = re;
    q.im = im;
    q.drain = (n_queued % DRAIN_GAP) == DRAIN_GAP / 2;
    request_q.push_back(q);
    n_queued++;
  endfunction

  function automatic logic [31:0] pick_part();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom();
      3, 4, 5: v = $urandom_range(0, 32'h0003_FFFF);
      6, 7: v = ONE + $urandom_range(0, 32'h1FFF) - 32'h1000;
      8: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
        return v;
      end
      default: v = $urandom_range(0, 255);
    endcase
    if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
    return v;
  endfunction

  // Driver: bursts of requests with random gaps; a drain request waits for
  // every outstanding result before it goes out.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
      n_accepted <= 0;
      acc_re = '0;
      acc_im = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_accumulator(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
        n_accepted <= n_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (request_q.size() != 0 &&
                     (!request_q[0].drain || (!s_axis_tvalid && n_accepted == n_returned))) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {request_q[0].im, request_q[0].re};
          s_axis_tuser <= request_q[0].op;
          request_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= 20)
      $display("[%0t] result %0d %s: got %h, expected %h", $realtime, n_returned, what, got,
               want);
  endtask

  // Monitor: check each result against the oldest prediction; the stall
  // pattern switches among four modes, drawn at random.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      n_returned <= 0;
      stall_tick <= 0;
      stall_mode <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (acc_results_due.size() == 0) begin
          report_mismatch("arrived with nothing due", m_axis_tdata[31:0], '0);
        end else begin
          due = acc_results_due.pop_front();
          if (m_axis_tdata[31:0] !== due.re)
            report_mismatch("result_real", m_axis_tdata[31:0], due.re);
          if (m_axis_tdata[63:32] !== due.im)
            report_mismatch("result_imag", m_axis_tdata[63:32], due.im);
          if (m_axis_tuser[0] !== due.ovf)
            report_mismatch("overflow", 32'(m_axis_tuser[0]), 32'(due.ovf));
          if (m_axis_tuser[1] !== due.dz)
            report_mismatch("divide_by_zero", 32'(m_axis_tuser[1]), 32'(due.dz));
        end
        n_returned <= n_returned + 1;
      end
      stall_tick <= stall_tick + 1;
      if (stall_tick % 256 == 255) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (stall_tick % 7) < 4;
        default: m_axis_tready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  initial begin
    int len;
    logic [1:0] op;
    logic [31:0] c, d;

    // directed corners
    queue_request(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(OP_ADD, 32'h0000_0001, 32'hFFFF_FFFF);
    queue_request(OP_LOAD, 32'h0000_0000, 32'h0000_0000);
    queue_request(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(OP_LOAD, 32'h0001_8000, 32'hFFFD_C000);
    queue_request(OP_MUL, 32'h0002_0000, 32'h0000_8000);
    queue_request(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    queue_request(OP_LOAD, 32'h8000_0000, 32'h8000_0000);
    queue_request(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    queue_request(OP_DIV, 32'h0000_0000, 32'h0000_0000);
    queue_request(OP_LOAD, 32'h0003_0000, 32'h0004_0000);
    queue_request(OP_DIV, ONE, 32'h0002_0000);
    queue_request(OP_DIV, 32'h8000_0000, 32'h8000_0000);
    queue_request(OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_request(OP_DIV, 32'h0000_0001, 32'h0000_0000);
    queue_request(OP_LOAD, 32'hFFFF_FFFF, 32'h0000_0001);
    queue_request(OP_MUL, 32'h0000_8000, 32'h0000_0000);
    queue_request(OP_DIV, 32'h0000_0000, 32'h0000_0001);
    queue_request(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(OP_MUL, 32'h0000_0000, 32'h0000_0000);
    queue_request(OP_DIV, 32'h0000_0000, 32'h0000_0000);
    queue_request(OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_request(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_request(OP_ADD, 32'h8000_0000, 32'h8000_0000);

    // random sequences, mostly led by a load
    while (n_queued < N_ITEMS) begin
      if ($urandom_range(0, 4) != 0) queue_request(OP_LOAD, pick_part(), pick_part());
      len = $urandom_range(1, 6);
      repeat (len) begin
        case ($urandom_range(0, 9))
          0, 1, 2: op = OP_ADD;
          3, 4, 5: op = OP_MUL;
          9: op = OP_LOAD;
          default: op = OP_DIV;
        endcase
        c = pick_part();
        d = pick_part();
        if (op == OP_DIV && $urandom_range(0, 11) == 0) begin
          c = '0;
          d = '0;
        end
        queue_request(op, c, d);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (request_q.size() != 0 || s_axis_tvalid) @(negedge clk);
    while (acc_results_due.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("Checked %0d requests: %0d loads, %0d adds, %0d multiplies, %0d divides.",
             n_accepted, op_seen[OP_LOAD], op_seen[OP_ADD], op_seen[OP_MUL], op_seen[OP_DIV]);
    $display("%0d results saturated, %0d divides by zero, %0d mismatches.",
             n_saturated, n_div_zero, n_errors);
    if (n_errors == 0 && acc_results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(25_000_000);
    $display("Timed out with %0d results outstanding", acc_results_due.size());
    $display("Verification failed");
    $finish;
  end

endmodule
